/* rtl/ssra_pkg.sv */
// ----------------------------------------------------------------------------
// ssra_pkg
// Shared types and constants of the shifted sub-filter response accumulator.
// ----------------------------------------------------------------------------
package ssra_pkg;

    // default geometry
    localparam int STEP_DEF    = 3;
    localparam int MAX_DIM_DEF = 64;
    localparam int MAX_SUB_DEF = 8;

    // payload widths
    localparam int SAMPLE_W   = 24;
    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int DIM_REG_W  = 7;
    localparam int SUB_REG_W  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESP_ROWS = 3'd0,
        REG_RESP_COLS = 3'd1,
        REG_OUT_ROWS  = 3'd2,
        REG_OUT_COLS  = 3'd3,
        REG_SUB_ROWS  = 3'd4,
        REG_SUB_COLS  = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } t_state;

    // per-item command from the address generator
    typedef struct packed {
        logic is_read;
        logic hit;
        logic last;
    } t_acc_flags;

endpackage

/* rtl/ssra_if.sv */
// ----------------------------------------------------------------------------
// ssra channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface ssra_in_if import ssra_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, operation, sample, input ready);
    modport sink   (input valid, operation, sample, output ready);
endinterface

interface ssra_out_if import ssra_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;
    logic                      saturated;

    modport source (output valid, out_value, out_last, saturated, input ready);
    modport sink   (input valid, out_value, out_last, saturated, output ready);
endinterface

interface ssra_cfg_if import ssra_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ssra_addr_gen.sv */
// ----------------------------------------------------------------------------
// ssra_addr_gen
// Register file, push/read position counters and store address generation.
// ----------------------------------------------------------------------------
module ssra_addr_gen import ssra_pkg::*; #(
    parameter  int STEP    = STEP_DEF,
    parameter  int MAX_DIM = MAX_DIM_DEF,
    parameter  int MAX_SUB = MAX_SUB_DEF,
    localparam int DEPTH   = MAX_DIM * MAX_DIM,
    localparam int ADDR_W  = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_step,
    input  t_op                   i_op,
    output logic [ADDR_W-1:0]     o_addr,
    output t_acc_flags            o_flags
);

    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int EFF_W  = $clog2(MAX_DIM + 1);
    localparam int SUB_W  = (MAX_SUB > 1) ? $clog2(MAX_SUB) : 1;
    localparam int SEFF_W = $clog2(MAX_SUB + 1);
    localparam int POS_W  = EFF_W + SUB_W + 5;
    localparam int PRD_W  = DIM_W + EFF_W;
    localparam int TOT_W  = $clog2(DEPTH + 1);

    function automatic logic [31:0] clamp_cfg(input logic [31:0] v, input logic [31:0] lim);
        if (v == 32'd0) begin
            return 32'd1;
        end
        return (v > lim) ? lim : v;
    endfunction

    logic [DIM_REG_W-1:0] r_resp_rows, r_resp_cols, r_out_rows, r_out_cols;
    logic [SUB_REG_W-1:0] r_sub_rows, r_sub_cols;

    logic [DIM_W-1:0]  r_map_row, r_map_col;
    logic [SUB_W-1:0]  r_sub_row, r_sub_col;
    logic [ADDR_W-1:0] r_read_idx;

    logic [EFF_W-1:0]  eff_rr, eff_rc, eff_or, eff_oc;
    logic [SEFF_W-1:0] eff_sr, eff_sc;

    logic [POS_W-1:0]  row_p, col_p, r0, c0, row_nx, col_nx, srow_nx, scol_nx;
    logic [DIM_W-1:0]  dr, dc;
    logic [PRD_W-1:0]  prod;
    logic [ADDR_W-1:0] push_addr, read_addr;
    logic [TOT_W-1:0]  total;
    logic              hit, last;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_rows <= DIM_REG_W'(1);
            r_resp_cols <= DIM_REG_W'(1);
            r_out_rows  <= DIM_REG_W'(1);
            r_out_cols  <= DIM_REG_W'(1);
            r_sub_rows  <= SUB_REG_W'(1);
            r_sub_cols  <= SUB_REG_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_RESP_ROWS: r_resp_rows <= i_cfg_data[DIM_REG_W-1:0];
                REG_RESP_COLS: r_resp_cols <= i_cfg_data[DIM_REG_W-1:0];
                REG_OUT_ROWS:  r_out_rows  <= i_cfg_data[DIM_REG_W-1:0];
                REG_OUT_COLS:  r_out_cols  <= i_cfg_data[DIM_REG_W-1:0];
                REG_SUB_ROWS:  r_sub_rows  <= i_cfg_data[SUB_REG_W-1:0];
                REG_SUB_COLS:  r_sub_cols  <= i_cfg_data[SUB_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_rr = EFF_W'(clamp_cfg(32'(r_resp_rows), 32'(MAX_DIM)));
        eff_rc = EFF_W'(clamp_cfg(32'(r_resp_cols), 32'(MAX_DIM)));
        eff_or = EFF_W'(clamp_cfg(32'(r_out_rows),  32'(MAX_DIM)));
        eff_oc = EFF_W'(clamp_cfg(32'(r_out_cols),  32'(MAX_DIM)));
        eff_sr = SEFF_W'(clamp_cfg(32'(r_sub_rows), 32'(MAX_SUB)));
        eff_sc = SEFF_W'(clamp_cfg(32'(r_sub_cols), 32'(MAX_SUB)));
    end

    // push: window test and store address
    always_comb begin
        row_p = POS_W'(r_map_row);
        col_p = POS_W'(r_map_col);
        r0    = POS_W'(32'(r_sub_row) * 32'(STEP));
        c0    = POS_W'(32'(r_sub_col) * 32'(STEP));
        hit   = (row_p < POS_W'(eff_rr)) && (col_p < POS_W'(eff_rc)) &&
                (row_p >= r0) && (row_p < r0 + POS_W'(eff_or)) &&
                (col_p >= c0) && (col_p < c0 + POS_W'(eff_oc));
        dr        = DIM_W'(row_p - r0);
        dc        = DIM_W'(col_p - c0);
        prod      = PRD_W'(dc) * PRD_W'(eff_or);
        push_addr = ADDR_W'(prod + PRD_W'(dr));

        row_nx  = row_p + POS_W'(1);
        col_nx  = col_p + POS_W'(1);
        srow_nx = POS_W'(r_sub_row) + POS_W'(1);
        scol_nx = POS_W'(r_sub_col) + POS_W'(1);
    end

    // read: restart when the index lies beyond the current map size
    always_comb begin
        total     = TOT_W'(TOT_W'(eff_or) * TOT_W'(eff_oc));
        read_addr = (TOT_W'(r_read_idx) >= total) ? '0 : r_read_idx;
        last      = (TOT_W'(read_addr) == total - TOT_W'(1));
    end

    always_comb begin
        o_addr          = (i_op == OP_READ) ? read_addr : push_addr;
        o_flags.is_read = (i_op == OP_READ);
        o_flags.hit     = hit;
        o_flags.last    = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_row  <= '0;
            r_map_col  <= '0;
            r_sub_row  <= '0;
            r_sub_col  <= '0;
            r_read_idx <= '0;
        end else if (i_step) begin
            if (i_op == OP_READ) begin
                r_read_idx <= last ? '0 : read_addr + ADDR_W'(1);
            end else if (row_nx < POS_W'(eff_rr)) begin
                r_map_row <= DIM_W'(row_nx);
            end else begin
                r_map_row <= '0;
                if (col_nx < POS_W'(eff_rc)) begin
                    r_map_col <= DIM_W'(col_nx);
                end else begin
                    r_map_col <= '0;
                    if (scol_nx < POS_W'(eff_sc)) begin
                        r_sub_col <= SUB_W'(scol_nx);
                    end else begin
                        r_sub_col <= '0;
                        r_sub_row <= (srow_nx < POS_W'(eff_sr)) ? SUB_W'(srow_nx) : '0;
                    end
                end
            end
        end
    end

endmodule

/* rtl/shifted_subfilter_response_accumulate_unit.sv */
// ----------------------------------------------------------------------------
// shifted_subfilter_response_accumulate_unit
// Adds shifted sub-filter response windows into a store and reads it out.
// ----------------------------------------------------------------------------
// Each item is accepted in IDLE, which issues the read of the one store entry
// it touches; the ACCESS state then writes back the saturated sum (a push
// inside the window) or zero (a read). A read holds in ACCESS while the
// previous result has not yet been transferred; pushes never wait on the
// output. The single-port-write store of MAX_DIM*MAX_DIM entries sets the
// pace. After reset a clearing pass over all MAX_DIM*MAX_DIM entries zeroes
// the store; items are held off during it, register writes are taken
// throughout.
module shifted_subfilter_response_accumulate_unit import ssra_pkg::*; #(
    parameter int STEP    = STEP_DEF,
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int MAX_SUB = MAX_SUB_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssra_cfg_if.sink   i_cfg,
    ssra_in_if.sink    i_in,
    ssra_out_if.source o_out
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic signed [VALUE_W-1:0] SUM_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] SUM_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    logic [VALUE_W-1:0] r_mem [DEPTH];

    t_state r_state, n_state;

    logic [ADDR_W-1:0]         r_clr_addr;
    logic [ADDR_W-1:0]         r_addr;
    logic                      r_is_read, r_hit, r_last, r_sat_cap;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [VALUE_W-1:0]        r_rd_data;
    logic                      r_sticky;

    logic                      r_out_valid, r_out_last, r_out_sat;
    logic signed [VALUE_W-1:0] r_out_value;

    logic [ADDR_W-1:0]  gen_addr;
    t_acc_flags         gen_flags;
    logic               accept, done, in_ready;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic signed [VALUE_W:0] sum;
    logic               sat_hi, sat_lo;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign accept      = i_in.valid && in_ready;

    ssra_addr_gen #(
        .STEP    (STEP),
        .MAX_DIM (MAX_DIM),
        .MAX_SUB (MAX_SUB)
    ) u_addr_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_idx  (i_cfg.index),
        .i_cfg_data (i_cfg.data),
        .i_step     (accept),
        .i_op       (t_op'(i_in.operation)),
        .o_addr     (gen_addr),
        .o_flags    (gen_flags)
    );

    // saturating add of the sample onto the entry
    always_comb begin
        sum    = {r_rd_data[VALUE_W-1], r_rd_data} +
                 {{(VALUE_W+1-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
        sat_hi = !sum[VALUE_W] && sum[VALUE_W-1];
        sat_lo = sum[VALUE_W] && !sum[VALUE_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        done      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                // a read waits for the output register to free up
                done = !r_is_read || !r_out_valid || o_out.ready;
                if (done) begin
                    n_state = ST_IDLE;
                    mem_we  = r_is_read || r_hit;
                    if (!r_is_read) begin
                        mem_wdata = sat_hi ? SUM_MAX :
                                    sat_lo ? SUM_MIN : sum[VALUE_W-1:0];
                    end
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // store: at most one write and one registered read (on accept) per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rd_data <= r_mem[gen_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr    <= gen_addr;
            r_is_read <= gen_flags.is_read;
            r_hit     <= gen_flags.hit;
            r_last    <= gen_flags.last;
            r_sample  <= i_in.sample;
            r_sat_cap <= r_sticky;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky <= 1'b0;
        end else if (accept && gen_flags.is_read && gen_flags.last) begin
            r_sticky <= 1'b0;
        end else if (done && !r_is_read && r_hit && (sat_hi || sat_lo)) begin
            r_sticky <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && r_is_read) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && r_is_read) begin
            r_out_value <= r_rd_data;
            r_out_last  <= r_last;
            r_out_sat   <= r_sat_cap;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = r_out_value;
    assign o_out.out_last  = r_out_last;
    assign o_out.saturated = r_out_sat;

endmodule

/* rtl/ssra_checker.sv */
// ----------------------------------------------------------------------------
// ssra_port_checks
// Port-level checks of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module ssra_port_checks import ssra_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_in_operation,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [VALUE_W-1:0] i_out_value,
    input logic                      i_out_last
);

    // the store is cleared first, so nothing is taken straight after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_in_ready)
        else $error("item taken during the clearing pass");

    // one item at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second item taken while one is in flight");

    // a push never waits on the output side
    a_push_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (t_op'(i_in_operation) == OP_PUSH))
            |=> ##1 i_in_ready)
        else $error("push did not complete in two cycles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
            |=> (i_out_valid && $stable(i_out_value) && $stable(i_out_last)))
        else $error("pending result changed before transfer");

endmodule

bind shifted_subfilter_response_accumulate_unit ssra_port_checks u_ssra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_value    (o_out.out_value),
    .i_out_last     (o_out.out_last)
);
